// ----- rtl/core/b64d_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// types, constants and the character map shared by the base64 decoder
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SLASH_CHAR = 8'h2F;
    localparam logic [7:0] BYTE_MASK  = 8'hFF;

    // byte counts of a group
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_THREE = 2'd3;

    // group positions
    localparam logic [1:0] POS_LAST = 2'd3;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_text;
    } b64d_in_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
        logic       status;
    } b64d_out_t;

    // one decoded group handed from front to back
    typedef struct packed {
        logic [23:0] triple;
        logic [1:0]  count;
        logic        last;
        logic        error;
    } b64d_job_t;

    function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = 8'd0;
            if (c >= 8'h41 && c <= 8'h5A)
            begin
                v = c - 8'h41;
            end
            else if (c >= 8'h61 && c <= 8'h7A)
            begin
                v = c - 8'h61 + 8'd26;
            end
            else if (c >= 8'h30 && c <= 8'h39)
            begin
                v = c - 8'h30 + 8'd52;
            end
            else if (c == PLUS_CHAR)
            begin
                v = 8'd62;
            end
            else if (c == SLASH_CHAR)
            begin
                v = 8'd63;
            end
            char_to_sextet = v[5:0];
        end
    endfunction

endpackage

// ----- rtl/core/b64d_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_front
// takes characters, maps them to sextets and assembles groups of four
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  b64d_pkg::b64d_in_t  in_item,
    output logic                job_valid,
    output b64d_pkg::b64d_job_t job
);
    import b64d_pkg::*;

    logic [17:0] acc_reg, acc_next;
    logic [1:0]  pos_reg, pos_next;
    logic        third_pad_reg, third_pad_next;

    logic       pad;
    logic [5:0] sextet;
    logic       last;

    assign pad    = (in_item.text_char == PAD_CHAR);
    assign sextet = pad ? 6'd0 : char_to_sextet(in_item.text_char & BYTE_MASK);
    assign last   = in_item.end_of_text;

    always_comb
    begin
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        third_pad_next = third_pad_reg;
        job_valid      = 1'b0;
        job.triple     = {acc_reg, sextet};
        job.count      = CNT_THREE - {1'b0, last & pad} - {1'b0, last & third_pad_reg};
        job.last       = last;
        job.error      = STATUS_OK;
        if (accept)
        begin
            if (pos_reg == POS_LAST)
            begin
                job_valid      = 1'b1;
                acc_next       = 18'd0;
                pos_next       = 2'd0;
                third_pad_next = 1'b0;
            end
            else if (last)
            begin
                // text ended inside a group
                job_valid      = 1'b1;
                job.triple     = 24'd0;
                job.count      = CNT_ONE;
                job.error      = STATUS_ERR;
                acc_next       = 18'd0;
                pos_next       = 2'd0;
                third_pad_next = 1'b0;
            end
            else
            begin
                acc_next = {acc_reg[11:0], sextet};
                pos_next = pos_reg + 2'd1;
                if (pos_reg == 2'd2)
                begin
                    third_pad_next = pad;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 18'd0;
            pos_reg       <= 2'd0;
            third_pad_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            pos_reg       <= pos_next;
            third_pad_reg <= third_pad_next;
        end
    end

endmodule

// ----- rtl/core/b64d_job_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_job_fifo
// short queue of decoded groups between front and back
// ----------------------------------------------------------------------------
module b64d_job_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  b64d_pkg::b64d_job_t wr_data,
    output logic                full,
    input  logic                rd_en,
    output b64d_pkg::b64d_job_t rd_data,
    output logic                empty
);
    import b64d_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    b64d_job_t     mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en & ~full;
    assign do_rd   = rd_en & ~empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- rtl/core/b64d_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_back
// splits each queued group into bytes and holds them in the output register
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_avail,
    input  b64d_pkg::b64d_job_t job,
    output logic                job_done,
    input  logic                pop,
    output logic                empty,
    output b64d_pkg::b64d_out_t out_item
);
    import b64d_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    b64d_out_t  out_reg, out_next;
    logic       load;
    logic       last_of_job;
    logic [7:0] sel_byte;

    assign empty       = ~out_valid_reg;
    assign out_item    = out_reg;
    assign load        = job_avail & (~out_valid_reg | pop);
    assign last_of_job = (idx_reg == job.count - 2'd1);
    assign job_done    = load & last_of_job;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = job.triple[23:16];
            2'd1:    sel_byte = job.triple[15:8];
            default: sel_byte = job.triple[7:0];
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (load)
        begin
            out_valid_next      = 1'b1;
            out_next.data_byte  = sel_byte;
            out_next.final_byte = job.last & last_of_job;
            out_next.status     = job.error;
            idx_next            = last_of_job ? 2'd0 : idx_reg + 2'd1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/core/base64_stream_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder
// standard-alphabet base64 text decoder, one character per transaction
// ----------------------------------------------------------------------------
// usage
//   input channel: drive in_item and raise push; the transaction completes on
//   a clock edge with push high and full low. end_of_text marks the final
//   character of a text
//   result channel: while empty is low out_item holds the oldest byte; it
//   leaves on a clock edge with pop high
// timing
//   one character is taken every cycle while the group queue has room
//   a group enters the queue when its fourth character is taken; its first
//   byte then moves to the output register, then one byte per cycle while
//   pop is high, so three bytes per four characters keep pace with the input
//   an unfinished final group gives a single error transaction instead
// stall behavior
//   a stalled receiver backs up the group queue (JOB_DEPTH entries) and the
//   output register; full rises only when the queue has no free entry
// reset
//   rst_n clears the group assembly, the queue and the output valid flag
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
    parameter int JOB_DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  b64d_pkg::b64d_in_t  in_item,
    output logic                empty,
    input  logic                pop,
    output b64d_pkg::b64d_out_t out_item
);
    import b64d_pkg::*;

    logic      accept;
    logic      job_wr;
    b64d_job_t job_in;
    b64d_job_t job_head;
    logic      job_empty;
    logic      job_done;

    // input transaction completes when the queue can take a group
    assign accept = push & ~full;

    // front: sextet mapping and group assembly
    b64d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_item   (in_item),
        .job_valid (job_wr),
        .job       (job_in)
    );

    // queue of completed groups
    b64d_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_job_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_wr),
        .wr_data (job_in),
        .full    (full),
        .rd_en   (job_done),
        .rd_data (job_head),
        .empty   (job_empty)
    );

    // back: byte sequencing into the output register
    b64d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (~job_empty),
        .job       (job_head),
        .job_done  (job_done),
        .pop       (pop),
        .empty     (empty),
        .out_item  (out_item)
    );

endmodule
